// ===== rtl/core/ccm_pkg.sv =====
`timescale 1ns / 1ps

package ccm_pkg;

    // Item opcodes
    localparam logic [1:0] OP_SET  = 2'd0;
    localparam logic [1:0] OP_LOAD = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // Slots reachable through the 4-bit entry index
    localparam int ADDR_SLOTS = 16;

    // Command queue depth between front and back
    localparam int CMD_DEPTH = 2;

    // Wildcard bit positions
    localparam int WC_MINUTE  = 0;
    localparam int WC_HOUR    = 1;
    localparam int WC_DAY     = 2;
    localparam int WC_MONTH   = 3;
    localparam int WC_WEEKDAY = 4;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [4:0]  wildcard_mask;
        logic [3:0]  entry_index;
        logic [15:0] job_id;
    } t_in_word;

    typedef struct packed {
        logic [11:0] match_year;
        logic [3:0]  match_month;
        logic [4:0]  match_day;
        logic [4:0]  match_hour;
        logic [5:0]  match_minute;
        logic [15:0] matched_job;
        logic [3:0]  matched_slot;
        logic        last;
    } t_out_word;

    // Classified command: the input word plus a day count congruent to the
    // weekday mod 7 (only meaningful for set items)
    typedef struct packed {
        t_in_word    word;
        logic [12:0] wday_sum;
    } t_cmd;

endpackage

// ===== rtl/core/ccm_front.sv =====
`timescale 1ns / 1ps

module ccm_front #(
    parameter int ENTRIES = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ccm_pkg::t_in_word i_in_word,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output ccm_pkg::t_cmd     o_cmd
);
    import ccm_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic        keep;
    logic        month_ok;
    logic        leap_adj;
    logic [11:0] yr_off;
    logic [9:0]  leap_days;
    logic [8:0]  db;

    // days before each month in a common year
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        begin
            unique case (m)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    // Drop unknown opcodes and loads past the table
    always_comb begin
        unique case (i_in_word.op)
            OP_SET:  keep = 1'b1;
            OP_TICK: keep = 1'b1;
            OP_LOAD: keep = int'(i_in_word.entry_index) < ENTRIES;
            default: keep = 1'b0;
        endcase
    end

    // Weekday sum: 1970-01-01 was a Thursday and 365 = 1 mod 7, so the
    // weekday is (year + leapdays + day + days_before + leap_adj) mod 7
    // for a valid month, and (year + leapdays + 1) mod 7 otherwise.
    always_comb begin
        month_ok  = (i_in_word.month >= 4'd1) && (i_in_word.month <= 4'd12);
        leap_adj  = (i_in_word.month >= 4'd3) && (i_in_word.year[1:0] == 2'b00);
        yr_off    = i_in_word.year - 12'd1973;
        leap_days = (i_in_word.year > 12'd1972) ? (10'(yr_off >> 2) + 10'd1) : 10'd0;
        db        = days_before(i_in_word.month);
        n_cmd.word = i_in_word;
        if (month_ok) begin
            n_cmd.wday_sum = 13'(i_in_word.year) + 13'(leap_days) + 13'(i_in_word.day)
                           + 13'(db) + 13'(leap_adj);
        end else begin
            n_cmd.wday_sum = 13'(i_in_word.year) + 13'(leap_days) + 13'd1;
        end
    end

    assign o_in_ready  = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid && keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/core/ccm_cmd_fifo.sv =====
`timescale 1ns / 1ps

module ccm_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccm_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_ready,
    output ccm_pkg::t_cmd o_cmd
);
    import ccm_pkg::*;

    localparam int PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        begin
            return (p == PTR_W'(CMD_DEPTH - 1)) ? '0 : p + PTR_W'(1);
        end
    endfunction

    assign o_ready = (r_count != CNT_W'(CMD_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/ccm_back.sv =====
`timescale 1ns / 1ps

module ccm_back #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  ccm_pkg::t_cmd      i_cmd,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccm_pkg::t_out_word o_out_word
);
    import ccm_pkg::*;

    localparam int SLOTS  = (ENTRIES < ADDR_SLOTS) ? ENTRIES : ADDR_SLOTS;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [2:0]  weekday;
        logic [4:0]  wild;
        logic [15:0] job;
    } t_entry;

    t_entry      r_table [SLOTS];
    logic [SLOTS-1:0] r_tvalid;
    logic [SLOTS-1:0] r_hits;
    logic        r_state;

    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [2:0]  r_wday;

    logic [11:0] n_year;
    logic [3:0]  n_month;
    logic [4:0]  n_day;
    logic [4:0]  n_hour;
    logic [5:0]  n_minute;
    logic [2:0]  n_wday;

    logic [11:0] r_snap_year;
    logic [3:0]  r_snap_month;
    logic [4:0]  r_snap_day;
    logic [4:0]  r_snap_hour;
    logic [5:0]  r_snap_minute;

    logic        r_out_valid;
    t_out_word   r_out;

    logic             pop;
    logic             out_free;
    logic             emit;
    logic [SLOTS-1:0] hit_vec;
    logic [SLOTS-1:0] rest;
    logic [SLOT_W-1:0] pick;
    logic [SLOT_W-1:0] load_slot;
    logic [4:0]        mlen;
    t_entry            wr_entry;

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] r;
        begin
            unique case (m)
                4'd2:    r = 5'd28;
                4'd4:    r = 5'd30;
                4'd6:    r = 5'd30;
                4'd9:    r = 5'd30;
                4'd11:   r = 5'd30;
                default: r = 5'd31;
            endcase
            return r;
        end
    endfunction

    // mod 7 by octal digit folding (8 = 1 mod 7)
    function automatic logic [2:0] mod7(input logic [12:0] s);
        logic [4:0] f1;
        logic [3:0] f2;
        begin
            f1 = 5'(s[2:0]) + 5'(s[5:3]) + 5'(s[8:6]) + 5'(s[11:9]) + 5'(s[12]);
            f2 = 4'(f1[2:0]) + 4'(f1[4:3]);
            return (f2 >= 4'd7) ? 3'(f2 - 4'd7) : f2[2:0];
        end
    endfunction

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign pop         = i_cmd_valid && o_cmd_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign emit        = (r_state == ST_SCAN) && (r_hits != '0) && out_free;
    assign load_slot   = i_cmd.word.entry_index[SLOT_W-1:0];
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        wr_entry.minute  = i_cmd.word.minute;
        wr_entry.hour    = i_cmd.word.hour;
        wr_entry.day     = i_cmd.word.day;
        wr_entry.month   = i_cmd.word.month;
        wr_entry.weekday = i_cmd.word.weekday;
        wr_entry.wild    = i_cmd.word.wildcard_mask;
        wr_entry.job     = i_cmd.word.job_id;
    end

    // All slots compared against the current minute in parallel
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            hit_vec[i] = r_tvalid[i]
                && (r_table[i].wild[WC_MINUTE]  || r_table[i].minute  == r_minute)
                && (r_table[i].wild[WC_HOUR]    || r_table[i].hour    == r_hour)
                && (r_table[i].wild[WC_DAY]     || r_table[i].day     == r_day)
                && (r_table[i].wild[WC_MONTH]   || r_table[i].month   == r_month)
                && (r_table[i].wild[WC_WEEKDAY] || r_table[i].weekday == r_wday);
        end
    end

    // Lowest pending hit
    always_comb begin
        pick = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hits[i]) begin
                pick = SLOT_W'(i);
            end
        end
        rest = r_hits & ~(SLOTS'(1) << pick);
    end

    // One-minute advance
    always_comb begin
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_wday   = r_wday;
        mlen     = month_len(r_month);
        if (r_month == 4'd2 && r_year[1:0] == 2'b00) begin
            mlen = 5'd29;
        end
        if (r_minute < 6'd59) begin
            n_minute = r_minute + 6'd1;
        end else begin
            n_minute = '0;
            if (r_hour < 5'd23) begin
                n_hour = r_hour + 5'd1;
            end else begin
                n_hour = '0;
                n_wday = (r_wday >= 3'd6) ? (r_wday - 3'd6) : (r_wday + 3'd1);
                if (r_day < mlen) begin
                    n_day = r_day + 5'd1;
                end else begin
                    n_day = 5'd1;
                    if (r_month >= 4'd1 && r_month < 4'd12) begin
                        n_month = r_month + 4'd1;
                    end else if (r_month == 4'd0) begin
                        n_month = 4'd1;
                    end else begin
                        n_month = 4'd1;
                        n_year  = r_year + 12'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_tvalid    <= '0;
            r_hits      <= '0;
            r_year      <= 12'd1970;
            r_month     <= 4'd1;
            r_day       <= 5'd1;
            r_hour      <= '0;
            r_minute    <= '0;
            r_wday      <= 3'd4;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        unique case (i_cmd.word.op)
                            OP_SET: begin
                                r_year   <= i_cmd.word.year;
                                r_month  <= i_cmd.word.month;
                                r_day    <= i_cmd.word.day;
                                r_hour   <= i_cmd.word.hour;
                                r_minute <= i_cmd.word.minute;
                                r_wday   <= mod7(i_cmd.wday_sum);
                            end
                            OP_LOAD: begin
                                r_tvalid[load_slot] <= 1'b1;
                            end
                            OP_TICK: begin
                                r_hits   <= hit_vec;
                                r_year   <= n_year;
                                r_month  <= n_month;
                                r_day    <= n_day;
                                r_hour   <= n_hour;
                                r_minute <= n_minute;
                                r_wday   <= n_wday;
                                r_state  <= ST_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_hits == '0) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_hits <= rest;
                        if (rest == '0) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.word.op == OP_LOAD) begin
            r_table[load_slot] <= wr_entry;
        end
        if (pop && i_cmd.word.op == OP_TICK) begin
            r_snap_year   <= r_year;
            r_snap_month  <= r_month;
            r_snap_day    <= r_day;
            r_snap_hour   <= r_hour;
            r_snap_minute <= r_minute;
        end
        if (emit) begin
            r_out.match_year   <= r_snap_year;
            r_out.match_month  <= r_snap_month;
            r_out.match_day    <= r_snap_day;
            r_out.match_hour   <= r_snap_hour;
            r_out.match_minute <= r_snap_minute;
            r_out.matched_job  <= r_table[pick].job;
            r_out.matched_slot <= 4'(pick);
            r_out.last         <= (rest == '0);
        end
    end

endmodule

// ===== rtl/core/calendar_clock_cron_matcher.sv =====
// Cron matcher with a minute-resolution calendar clock. Input words carry an
// op: set time (loads year/month/day/hour/minute, weekday derived from the
// 1970 epoch), load entry (writes one table slot with patterns, wildcard
// bits and a job id; slots at or past ENTRIES are dropped) or tick. A tick
// emits one output word per valid matching slot, lowest slot first, stamped
// with the time before the advance and with last set on the final one, and
// steps the clock by one minute. Day and weekday must both match. Structure: a
// front stage classifies each word and pre-computes the weekday sum, then a
// two-entry command queue feeds the execution unit. Set and load are applied
// when the execution unit takes them; a tick compares all slots in parallel
// and advances the clock, then emits one matching slot per cycle while the
// output is taken, and leaves the scan state without output when nothing
// matches. The output register lets the front keep accepting words while
// results wait. The table has no reset sweep; only its valid bits clear.
`timescale 1ns / 1ps

module calendar_clock_cron_matcher #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ccm_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ccm_pkg::t_out_word o_out_word
);
    import ccm_pkg::*;

    // front -> queue
    logic fe_valid;
    logic fe_ready;
    t_cmd fe_cmd;

    // queue -> execution unit
    logic q_valid;
    logic q_ready;
    t_cmd q_cmd;

    ccm_front #(
        .ENTRIES (ENTRIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (fe_valid),
        .i_cmd_ready (fe_ready),
        .o_cmd       (fe_cmd)
    );

    ccm_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fe_valid),
        .o_ready (fe_ready),
        .i_cmd   (fe_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    ccm_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== bench/calendar_clock_cron_matcher_tb.sv =====
`timescale 1ns / 1ps

module calendar_clock_cron_matcher_tb;
    import ccm_pkg::*;

    // op 3 is not decoded by the block; it must be swallowed silently
    localparam logic [1:0] OP_NONE = 2'd3;

    // generous ceiling: worst case is 16 matches per tick, each stalled by
    // the longest drawn wait, plus the longest drawn input gap on every word
    localparam int RUN_LIMIT_NS = 4_000_000;

    // cycles to linger after the last expected match
    localparam int DRAIN_CYCLES = 40;

    // one queued input word plus its pacing hints
    typedef struct {
        t_in_word word;
        bit       hold;   // wait for all matches to drain before presenting
        bit       brisk;  // no gap after this word
    } t_feed;

    // one cron table slot as the predictor keeps it
    typedef struct packed {
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [2:0]  wday;
        logic [4:0]  wild;
        logic [15:0] job;
    } t_cron_entry;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in_word   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    calendar_clock_cron_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // ------------------------------------------------------------------
    // Predicted clock and cron table. State starts at the reset values:
    // 1970-01-01 00:00, a Thursday, with no valid slot.
    // ------------------------------------------------------------------
    logic [11:0] cur_year  = 12'd1970;
    logic [3:0]  cur_month = 4'd1;
    logic [4:0]  cur_day   = 5'd1;
    logic [4:0]  cur_hour  = 5'd0;
    logic [5:0]  cur_min   = 6'd0;
    logic [2:0]  cur_wday  = 3'd4;
    t_cron_entry cron_table [ADDR_SLOTS];
    logic [ADDR_SLOTS-1:0] slot_used = '0;

    t_feed     word_q[$];           // words waiting to be driven
    t_out_word pending_matches[$];  // match words still owed by the block
    int        fails     = 0;
    int        n_matches = 0;
    int        in_gap    = 0;
    int        out_wait  = 0;
    int        out_draw;

    // days ahead of each month in a common year; invalid months count none
    function automatic int days_before(input int mo);
        case (mo)
            2:       return 31;
            3:       return 59;
            4:       return 90;
            5:       return 120;
            6:       return 151;
            7:       return 181;
            8:       return 212;
            9:       return 243;
            10:      return 273;
            11:      return 304;
            12:      return 334;
            default: return 0;
        endcase
    endfunction

    // month length for rollover; invalid months are 31 days long
    function automatic int month_length(input int mo, input int y);
        case (mo)
            2:           return (y % 4 == 0) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // weekday from the 1970 epoch (Thursday); years below 1970 give a
    // negative sum that is folded back into 0..6
    function automatic logic [2:0] weekday_of(input int y, input int mo, input int d);
        int doy;
        int leap_days;
        int total;
        doy = 0;
        leap_days = 0;
        if (mo >= 1 && mo <= 12) begin
            doy = d - 1 + days_before(mo);
            if (mo >= 3 && y % 4 == 0)
                doy += 1;
        end
        if (y > 1972)
            leap_days = (y - 1973) / 4 + 1;
        total = (4 + (y - 1970) * 365 + leap_days + doy) % 7;
        if (total < 0)
            total += 7;
        return total[2:0];
    endfunction

    function automatic bit entry_hits(input t_cron_entry e);
        if (!e.wild[WC_MINUTE]  && e.minute != cur_min)   return 1'b0;
        if (!e.wild[WC_HOUR]    && e.hour   != cur_hour)  return 1'b0;
        if (!e.wild[WC_DAY]     && e.day    != cur_day)   return 1'b0;
        if (!e.wild[WC_MONTH]   && e.month  != cur_month) return 1'b0;
        if (!e.wild[WC_WEEKDAY] && e.wday   != cur_wday)  return 1'b0;
        return 1'b1;
    endfunction

    // one-minute advance; odd values (minute 63, hour 31, month 0 or 15)
    // carry the same way the block does
    task automatic step_minute();
        if (cur_min < 6'd59) begin
            cur_min = cur_min + 6'd1;
        end else begin
            cur_min = 6'd0;
            if (cur_hour < 5'd23) begin
                cur_hour = cur_hour + 5'd1;
            end else begin
                cur_hour = 5'd0;
                cur_wday = 3'((int'(cur_wday) + 1) % 7);
                if (cur_day < month_length(cur_month, cur_year)) begin
                    cur_day = cur_day + 5'd1;
                end else begin
                    cur_day = 5'd1;
                    if (cur_month >= 4'd1 && cur_month < 4'd12) begin
                        cur_month = cur_month + 4'd1;
                    end else if (cur_month == 4'd0) begin
                        cur_month = 4'd1;
                    end else begin
                        cur_month = 4'd1;
                        cur_year  = cur_year + 12'd1;  // wraps at 4096
                    end
                end
            end
        end
    endtask

    // apply one accepted word to the predicted state and queue the matches
    task automatic apply_word(input t_in_word w);
        t_out_word hit;
        t_out_word held;
        bit        have_held;
        have_held = 1'b0;
        case (w.op)
            OP_SET: begin
                cur_year  = w.year;
                cur_month = w.month;
                cur_day   = w.day;
                cur_hour  = w.hour;
                cur_min   = w.minute;
                cur_wday  = weekday_of(w.year, w.month, w.day);
            end
            OP_LOAD: begin
                if (w.entry_index < ADDR_SLOTS) begin
                    cron_table[w.entry_index] = '{minute: w.minute, hour: w.hour,
                        day: w.day, month: w.month, wday: w.weekday,
                        wild: w.wildcard_mask, job: w.job_id};
                    slot_used[w.entry_index] = 1'b1;
                end
            end
            OP_TICK: begin
                // slots in ascending order, stamped with the pre-advance time;
                // each hit is held back one step so the final one gets last
                for (int s = 0; s < ADDR_SLOTS; s++) begin
                    if (slot_used[s] && entry_hits(cron_table[s])) begin
                        hit = '{match_year: cur_year, match_month: cur_month,
                            match_day: cur_day, match_hour: cur_hour,
                            match_minute: cur_min, matched_job: cron_table[s].job,
                            matched_slot: 4'(s), last: 1'b0};
                        if (have_held)
                            pending_matches.insert(pending_matches.size(), held);
                        held = hit;
                        have_held = 1'b1;
                    end
                end
                if (have_held) begin
                    held.last = 1'b1;
                    pending_matches.insert(pending_matches.size(), held);
                end
                step_minute();
            end
            default: ;  // unknown op: nothing happens
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    task automatic check_match(input t_out_word got);
        t_out_word want;
        if (pending_matches.size() == 0) begin
            $error("match word with none owed: job %0d slot %0d",
                   got.matched_job, got.matched_slot);
            fails++;
        end else begin
            want = pending_matches.pop_front();
            check_field("match_year",   want.match_year,   got.match_year);
            check_field("match_month",  want.match_month,  got.match_month);
            check_field("match_day",    want.match_day,    got.match_day);
            check_field("match_hour",   want.match_hour,   got.match_hour);
            check_field("match_minute", want.match_minute, got.match_minute);
            check_field("matched_job",  want.matched_job,  got.matched_job);
            check_field("matched_slot", want.matched_slot, got.matched_slot);
            check_field("last",         want.last,         got.last);
        end
    endtask

    // ------------------------------------------------------------------
    // Word builders. Fields an op does not use are left random so that
    // the block is seen to ignore them.
    // ------------------------------------------------------------------
    function automatic t_in_word noise_word();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[61:0];
    endfunction

    function automatic t_in_word set_word(input int y, input int mo, input int d,
                                          input int h, input int mi);
        t_in_word w;
        w = noise_word();
        w.op     = OP_SET;
        w.year   = 12'(y);
        w.month  = 4'(mo);
        w.day    = 5'(d);
        w.hour   = 5'(h);
        w.minute = 6'(mi);
        return w;
    endfunction

    function automatic t_in_word load_word(input int idx, input int mi, input int h,
                                           input int d, input int mo, input int wd,
                                           input int wc, input int job);
        t_in_word w;
        w = noise_word();
        w.op            = OP_LOAD;
        w.entry_index   = 4'(idx);
        w.minute        = 6'(mi);
        w.hour          = 5'(h);
        w.day           = 5'(d);
        w.month         = 4'(mo);
        w.weekday       = 3'(wd);
        w.wildcard_mask = 5'(wc);
        w.job_id        = 16'(job);
        return w;
    endfunction

    function automatic t_in_word tick_word();
        t_in_word w;
        w = noise_word();
        w.op = OP_TICK;
        return w;
    endfunction

    task automatic feed(input t_in_word w, input bit hold = 1'b0, input bit brisk = 1'b0);
        t_feed f;
        f = '{word: w, hold: hold, brisk: brisk};
        word_q.insert(word_q.size(), f);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Input driver: pops word_q, holds each word until accepted, then
    // idles for the drawn gap. A hold word waits for all matches first.
    // Every accepted word goes through the predictor at the same edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready)
                apply_word(i_in_word);
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (word_q.size() > 0 &&
                             !(word_q[0].hold && pending_matches.size() > 0)) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= word_q[0].word;
                    in_gap     <= word_q[0].brisk ? 0 : $urandom_range(0, 5);
                    void'(word_q.pop_front());
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: checks every taken match word, then stalls ready
    // for a drawn number of cycles. Every third block of 24 matches is
    // taken back to back.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_wait    <= 0;
        end else if (o_out_valid && i_out_ready) begin
            check_match(o_out_word);
            n_matches++;
            out_draw = ((n_matches / 24) % 3 == 2) ? 0 : $urandom_range(0, 5);
            out_wait    <= out_draw;
            i_out_ready <= (out_draw == 0);
        end else if (out_wait > 0) begin
            out_wait    <= out_wait - 1;
            i_out_ready <= (out_wait == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int       n_words;
        bit       hold;
        bit       brisk;
        int       y, mo, d, h, mi, len, wd0;
        int       pm, ph, pd, pmo, pwd, wc;
        t_in_word w;

        // --- directed part ---
        // tick on an empty table at the reset time: no matches
        feed(tick_word());
        // slot 0: every wildcard, patterns at their field maxima
        feed(load_word(0, 63, 31, 31, 15, 7, 5'b11111, 16'hFFFF));
        // slot 15: exactly 1970-01-01 00:01, Thursday, no wildcard
        feed(load_word(15, 1, 0, 1, 1, 4, 5'b00000, 16'h0000));
        feed(tick_word(), 1'b0, 1'b1);  // 00:01, slots 0 and 15
        feed(tick_word(), 1'b0, 1'b1);  // 00:02, slot 0 only
        // weekday pattern 7 never matches while its wildcard is clear
        feed(load_word(7, 0, 0, 1, 1, 7, 5'b01111, 16'h1234));
        // end of the last supported year, rolls into 2100
        feed(set_word(2099, 12, 31, 23, 59));
        feed(tick_word());
        feed(tick_word());
        // leap February: 28th -> 29th; common February: 28th -> March 1st
        feed(set_word(2024, 2, 28, 23, 59));
        feed(tick_word());
        feed(set_word(2023, 2, 28, 23, 59));
        feed(tick_word());
        // year field at its maximum wraps to 0
        feed(set_word(4095, 12, 31, 23, 59));
        feed(tick_word());
        // out-of-range set time: month 0, day 0, hour 31, minute 63, year 0
        feed(set_word(0, 0, 0, 31, 63));
        feed(tick_word());
        // invalid month 15 at the end of its 31-day span
        feed(set_word(1970, 15, 31, 23, 59));
        feed(tick_word());
        // unknown op
        w = noise_word();
        w.op = OP_NONE;
        feed(w);
        // exact match just past the first leap-day boundary, weekday AND-ed
        feed(set_word(1973, 3, 1, 12, 0));
        feed(load_word(3, 0, 12, 1, 3, weekday_of(1973, 3, 1), 5'b00000, 16'hA5A5));
        feed(tick_word());

        // --- random part: set time near a boundary, load entries aimed at
        // the coming minutes, tick through them; some noise between ---
        n_words = 0;
        while (n_words < 420) begin
            hold  = (n_words == 0) || ($urandom_range(0, 7) == 0);
            brisk = ($urandom_range(0, 3) == 0);
            y   = $urandom_range(1970, 2099);
            mo  = $urandom_range(1, 12);
            len = month_length(mo, y);
            d   = $urandom_range(0, 1) ? len : $urandom_range(1, len);
            h   = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
            mi  = $urandom_range(0, 3) ? $urandom_range(50, 59) : $urandom_range(0, 59);
            wd0 = weekday_of(y, mo, d);
            feed(set_word(y, mo, d, h, mi), hold, brisk);
            n_words++;
            repeat ($urandom_range(1, 3)) begin
                pm  = $urandom_range(0, 1) ? $urandom_range(mi, 59) : $urandom_range(0, 3);
                ph  = $urandom_range(0, 1) ? h : (h + 1) % 24;
                pd  = $urandom_range(0, 1) ? d : 1;
                pmo = $urandom_range(0, 1) ? mo : mo % 12 + 1;
                pwd = $urandom_range(0, 1) ? wd0 : (wd0 + 1) % 7;
                wc  = $urandom_range(0, 31) & $urandom_range(0, 31);
                if ($urandom_range(0, 5) == 0)
                    wc = $urandom_range(0, 1) ? 5'b11110 : 5'b11111;
                if ($urandom_range(0, 9) == 0)
                    pwd = 7;  // unreachable weekday pattern
                feed(load_word($urandom_range(0, 15), pm, ph, pd, pmo, pwd, wc,
                               $urandom_range(0, 16'hFFFF)), 1'b0, brisk);
                n_words++;
            end
            repeat ($urandom_range(4, 14)) begin
                feed(tick_word(), 1'b0, brisk);
                n_words++;
            end
            // fully random words, including odd set times and op 3
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    w = noise_word();
                    feed(w);
                    if (w.op != OP_NONE)
                        n_words++;
                end
            end
        end

        // reset: held low from time zero, released on a rising edge
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every word to go in and every owed match to come out
        while (word_q.size() > 0 || i_in_valid || pending_matches.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ccm_pkg.sv
rtl/core/ccm_front.sv
rtl/core/ccm_cmd_fifo.sv
rtl/core/ccm_back.sv
rtl/core/calendar_clock_cron_matcher.sv
bench/calendar_clock_cron_matcher_tb.sv
